[rtl/kth_anc_pkg.sv]
// Shared types and constants for the k-th ancestor block.
// Item structs, item kind codes and the jump table entry layout.
// No dependencies.
package kth_anc_pkg;

    // Node fields and jump table entries
    localparam int NODE_BITS   = 10;
    localparam int ENTRY_W     = 11;
    localparam int PRESENT_BIT = 10;
    localparam int STEP_BITS   = 16;
    localparam int COUNT_BITS  = 11;
    // Width that holds any node count and the largest table size
    localparam int CMP_W       = 17;

    // Item kind codes
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [NODE_BITS-1:0] node_id;
        logic [NODE_BITS-1:0] parent_node;
        logic                 is_root;
        logic [STEP_BITS-1:0] step_count;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [NODE_BITS-1:0] ancestor_node;
    } out_item_t;

endpackage

[rtl/kth_anc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kth_anc_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 10240,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/kth_ancestor_binary_lifting.sv]
// Top level of the k-th ancestor block (binary lifting over a jump table).
// Depends on kth_anc_pkg and kth_anc_ram.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries three kinds of item.
//   A load item writes a node's direct parent (or marks it as root) into
//   level 0 of the jump table as it is accepted; the block stays idle.
//   A build item fills levels 1..LOG_LEVELS-1 for nodes below node_count
//   (capped at MAX_NODES) through the single table RAM: per entry ST_BRD1
//   reads the entry one level down, ST_BRD2 reads the ancestor's entry there
//   and ST_BWR writes it; with no ancestor ST_BRD2 writes an empty entry.
//   A query item climbs one level per cycle from the top level down, with
//   a wait state for each set bit of K on the registered RAM read.
//   A K with bits at or above LOG_LEVELS answers not-found without a read.
//   Only queries give a result, on out_valid / out_stall / out_item.
//   in_stall is high while an item is at work. A result held by out_stall
//   sits in the output register; loads and builds are still accepted, and a
//   following query finishes once that register is free.
//   cfg_we / cfg_data write node_count only while the block is idle; the user
//   keeps to this, the block does not enforce it. Reset clears the sequencer
//   and sets node_count to 1024; entries are undefined until loaded or built.
module kth_ancestor_binary_lifting
    import kth_anc_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_data
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LVL_W  = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int ADDR_W = LVL_W + NODE_W;
    localparam int DEPTH  = LOG_LEVELS * (2 ** NODE_W);
    localparam int CNT_W  = NODE_W + 1;

    localparam logic [CMP_W-1:0] MAX_L    = CMP_W'(MAX_NODES);
    localparam logic [LVL_W-1:0] TOP_LVL  = LVL_W'(LOG_LEVELS - 1);
    localparam logic [LVL_W:0]   LEVELS_L = (LVL_W + 1)'(LOG_LEVELS);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QSCAN = 3'd1;
    localparam logic [2:0] ST_QWAIT = 3'd2;
    localparam logic [2:0] ST_QDONE = 3'd3;
    localparam logic [2:0] ST_BRD1  = 3'd4;
    localparam logic [2:0] ST_BRD2  = 3'd5;
    localparam logic [2:0] ST_BWR   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [NODE_W-1:0]     v_reg, v_next;
    logic [LOG_LEVELS-1:0] k_reg, k_next;
    logic [NODE_BITS-1:0]  cur_reg, cur_next;
    logic                  found_reg, found_next;
    logic [COUNT_BITS-1:0] node_count_reg;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]    rd_data;

    logic                  accept;
    logic                  slot_free;
    logic [CNT_W-1:0]      cnt_sat;
    logic [CNT_W-1:0]      v_inc;
    logic [LVL_W:0]        lvl_inc;
    logic [LVL_W-1:0]      lvl_prev;
    logic [NODE_BITS-1:0]  rd_node;
    logic                  rd_present;
    logic                  rd_node_ok;
    logic                  cur_ok;
    logic                  in_node_ok;
    logic                  k_high;
    logic                  advance;

    kth_anc_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    // Saturated node count, counters and range checks
    assign cnt_sat = (CMP_W'(node_count_reg) > MAX_L) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_reg);
    assign v_inc      = {1'b0, v_reg} + 1'b1;
    assign lvl_inc    = {1'b0, lvl_reg} + 1'b1;
    assign lvl_prev   = lvl_reg - 1'b1;
    assign rd_node    = rd_data[NODE_BITS-1:0];
    assign rd_present = rd_data[PRESENT_BIT];
    assign rd_node_ok = CMP_W'(rd_node) < MAX_L;
    assign cur_ok     = CMP_W'(cur_reg) < MAX_L;
    assign in_node_ok = CMP_W'(in_item.node_id) < MAX_L;
    assign k_high     = (in_item.step_count >> LOG_LEVELS) != '0;

    // Sequencer and table access
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        wr_addr        = {lvl_reg, v_reg};
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = {lvl_reg, NODE_W'(cur_reg)};
        advance        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.kind)
                        KIND_LOAD:
                        begin
                            ram_we  = in_node_ok;
                            wr_addr = {LVL_W'(0), NODE_W'(in_item.node_id)};
                            wr_data = in_item.is_root ? ENTRY_W'(0)
                                                      : {1'b1, in_item.parent_node};
                        end
                        KIND_BUILD:
                        begin
                            if (LOG_LEVELS > 1 && cnt_sat != '0)
                            begin
                                state_next = ST_BRD1;
                                lvl_next   = LVL_W'(1);
                                v_next     = '0;
                            end
                        end
                        KIND_QUERY:
                        begin
                            cur_next   = in_item.node_id;
                            k_next     = in_item.step_count[LOG_LEVELS-1:0];
                            lvl_next   = TOP_LVL;
                            found_next = !k_high;
                            state_next = k_high ? ST_QDONE : ST_QSCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_QSCAN:
            begin
                if (k_reg[lvl_reg])
                begin
                    if (cur_ok)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_QWAIT;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        state_next = ST_QDONE;
                    end
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_QDONE;
                end
                else
                begin
                    lvl_next = lvl_prev;
                end
            end
            ST_QWAIT:
            begin
                if (!rd_present)
                begin
                    found_next = 1'b0;
                    state_next = ST_QDONE;
                end
                else
                begin
                    cur_next = rd_node;
                    if (lvl_reg == '0)
                    begin
                        state_next = ST_QDONE;
                    end
                    else
                    begin
                        lvl_next   = lvl_prev;
                        state_next = ST_QSCAN;
                    end
                end
            end
            ST_QDONE:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.found         = found_reg;
                    out_item_next.ancestor_node = found_reg ? cur_reg : '0;
                    state_next                  = ST_IDLE;
                end
            end
            ST_BRD1:
            begin
                // entry of v one level down
                rd_en      = 1'b1;
                rd_addr    = {lvl_prev, v_reg};
                state_next = ST_BRD2;
            end
            ST_BRD2:
            begin
                if (rd_present && rd_node_ok)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {lvl_prev, NODE_W'(rd_node)};
                    state_next = ST_BWR;
                end
                else
                begin
                    // no ancestor at this level
                    ram_we  = 1'b1;
                    wr_data = '0;
                    advance = 1'b1;
                end
            end
            ST_BWR:
            begin
                ram_we  = 1'b1;
                wr_data = rd_data;
                advance = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Next node, then next level, then done
        if (advance)
        begin
            if (v_inc < cnt_sat)
            begin
                v_next     = v_inc[NODE_W-1:0];
                state_next = ST_BRD1;
            end
            else if (lvl_inc < LEVELS_L)
            begin
                v_next     = '0;
                lvl_next   = lvl_inc[LVL_W-1:0];
                state_next = ST_BRD1;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            node_count_reg <= COUNT_BITS'(1024);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        found_reg    <= found_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTH
    // A query never writes the table
    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QSCAN || state_reg == ST_QWAIT) |-> !ram_we)
        else $error("table written during a query");

    // A build never overwrites level 0
    a_build_level: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_IDLE) |-> (wr_addr[ADDR_W-1:NODE_W] != '0))
        else $error("build wrote level 0");

    // The read wait follows a scan step that issued the read
    a_wait_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QSCAN && state_next == ST_QWAIT) |-> rd_en)
        else $error("read wait without a read");

    // A finished query shows its result in the next cycle
    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QDONE && slot_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("query result not delivered");
`endif

endmodule

[tb/kth_anc_checker.sv]
// Checker for the k-th ancestor block: watches the item channels and the
// config port, keeps its own jump table and compares every result item.
// Depends on kth_anc_pkg.
`timescale 1ns / 100ps

module kth_anc_checker
    import kth_anc_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    // Entry (v, j): bit 10 = ancestor present, bits 9..0 = the 2^j-th ancestor
    logic [ENTRY_W-1:0]    ancestor_tbl [MAX_NODES][LOG_LEVELS];
    logic [COUNT_BITS-1:0] span_cfg;
    out_item_t             expected_ancestors [$];

    // Out-of-range nodes or levels read as "no ancestor"
    function automatic logic [ENTRY_W-1:0] entry_at(int node, int lvl);
        if (node >= MAX_NODES || lvl >= LOG_LEVELS)
        begin
            return '0;
        end
        return ancestor_tbl[node][lvl];
    endfunction

    // Fill levels 1..LOG_LEVELS-1 for nodes below the saturated node count
    task automatic rebuild_levels();
        int                 span;
        logic [ENTRY_W-1:0] hop;
        span = (span_cfg > MAX_NODES) ? MAX_NODES : int'(span_cfg);
        for (int j = 1; j < LOG_LEVELS; j++)
        begin
            for (int v = 0; v < span; v++)
            begin
                hop = entry_at(v, j - 1);
                ancestor_tbl[v][j] = hop[PRESENT_BIT] ?
                    entry_at(int'(hop[NODE_BITS-1:0]), j - 1) : ENTRY_W'(0);
            end
        end
    endtask

    // Climb by the set bits of K, top level first
    function automatic out_item_t climb_from(logic [NODE_BITS-1:0] start,
                                             logic [STEP_BITS-1:0] steps);
        out_item_t            res;
        logic                 ok;
        logic [NODE_BITS-1:0] cur;
        logic [ENTRY_W-1:0]   hop;
        ok  = (LOG_LEVELS >= STEP_BITS) || ((steps >> LOG_LEVELS) == 0);
        cur = start;
        for (int lvl = LOG_LEVELS - 1; lvl >= 0; lvl--)
        begin
            if (ok && steps[lvl])
            begin
                hop = entry_at(int'(cur), lvl);
                if (!hop[PRESENT_BIT])
                    ok = 1'b0;
                else
                    cur = hop[NODE_BITS-1:0];
            end
        end
        res.found         = ok;
        res.ancestor_node = ok ? cur : '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            span_cfg   = 11'd1024;
            expected_ancestors.delete();
            // Entries never loaded read as "no ancestor"
            for (int v = 0; v < MAX_NODES; v++)
            begin
                for (int j = 0; j < LOG_LEVELS; j++)
                begin
                    ancestor_tbl[v][j] = '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
                span_cfg = cfg_data;

            // Result side first: a query taken at this edge cannot answer yet
            if (out_valid && !out_stall)
            begin
                if (expected_ancestors.size() == 0)
                begin
                    $error("unexpected result item: found=%0d ancestor_node=%0d",
                           out_item.found, out_item.ancestor_node);
                    mismatches++;
                end
                else
                begin
                    want = expected_ancestors.pop_front();
                    if (out_item.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, out_item.found);
                        mismatches++;
                    end
                    if (out_item.ancestor_node !== want.ancestor_node)
                    begin
                        $error("ancestor_node: expected %0d, got %0d",
                               want.ancestor_node, out_item.ancestor_node);
                        mismatches++;
                    end
                end
            end

            // Input side: update the table or queue the answer
            if (in_valid && !in_stall)
            begin
                case (in_item.kind)
                    KIND_LOAD:
                    begin
                        if (int'(in_item.node_id) < MAX_NODES)
                            ancestor_tbl[in_item.node_id][0] = in_item.is_root ?
                                ENTRY_W'(0) : {1'b1, in_item.parent_node};
                    end
                    KIND_BUILD:
                        rebuild_levels();
                    KIND_QUERY:
                        expected_ancestors.insert(expected_ancestors.size(),
                            climb_from(in_item.node_id, in_item.step_count));
                    default:
                        ;
                endcase
            end
        end
        outstanding = expected_ancestors.size();
    end

endmodule

[tb/kth_ancestor_binary_lifting_tb.sv]
// Testbench top for the k-th ancestor block: clock, reset, item stimulus,
// config writes and the final verdict. Depends on kth_anc_pkg, the block
// and kth_anc_checker.
`timescale 1ns / 100ps

module kth_ancestor_binary_lifting_tb
    import kth_anc_pkg::*;
();

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    // Build cost per node in the build range
    localparam int BUILD_CYC  = 3 * (LOG_LEVELS - 1);
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int ITEM_GOAL   = 600;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef enum {SHAPE_CHAIN, SHAPE_SPREAD, SHAPE_NEAR, SHAPE_LOOPY} shape_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [COUNT_BITS-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int items_sent = 0;
    int snd_idle = 32;
    int rcv_idle = 73;
    int cur_cfg = 1024;

    kth_ancestor_binary_lifting #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    kth_anc_checker #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result-side backpressure
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99, 0) < rcv_idle);
    end

    function automatic in_item_t mk_item(logic [1:0] kind, int node, int parent,
                                         bit root, logic [STEP_BITS-1:0] steps);
        in_item_t it;
        it.kind        = kind;
        it.node_id     = NODE_BITS'(node);
        it.parent_node = NODE_BITS'(parent);
        it.is_root     = root;
        it.step_count  = steps;
        return it;
    endfunction

    // K: zero, out-of-table, or spread over the table's levels
    function automatic logic [STEP_BITS-1:0] pick_steps();
        int r;
        int w;
        r = $urandom_range(99, 0);
        w = $urandom_range(LOG_LEVELS, 1);
        if (r < 10)
            return '0;
        if (r < 22)
            return STEP_BITS'($urandom_range(65535, 1 << LOG_LEVELS));
        return STEP_BITS'($urandom_range((1 << w) - 1, 1));
    endfunction

    function automatic int pick_parent(int v, int span, shape_t shp);
        case (shp)
            SHAPE_CHAIN:  return ($urandom_range(99, 0) < 90) ? v - 1 : $urandom_range(v - 1, 0);
            SHAPE_SPREAD: return $urandom_range(v - 1, 0);
            SHAPE_NEAR:   return $urandom_range(v - 1, (v > 4) ? v - 4 : 0);
            default:      return $urandom_range(span - 1, 0);
        endcase
    endfunction

    // Present one item at the falling edge and hold it until taken
    task automatic send(in_item_t it);
        items_sent++;
        if (items_sent < ITEM_GOAL / 3)
        begin
            snd_idle = 32;
            rcv_idle = 73;
        end
        else if (items_sent < 2 * ITEM_GOAL / 3)
        begin
            snd_idle = 73;
            rcv_idle = 32;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        while ($urandom_range(99, 0) < snd_idle)
            @(negedge clk);
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_results();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // All results in, then room for a build still running
    task automatic settle();
        wait_results();
        repeat (BUILD_CYC * ((cur_cfg > MAX_NODES) ? MAX_NODES : cur_cfg) + 50)
            @(negedge clk);
    endtask

    task automatic write_span(int value);
        settle();
        cfg_we   = 1'b1;
        cfg_data = COUNT_BITS'(value);
        @(negedge clk);
        cfg_we   = 1'b0;
        cur_cfg  = value;
    endtask

    // Items that never read the table: unknown kind, root loads outside the
    // tree, zero-step and out-of-table queries
    task automatic rand_noise(int span);
        int r;
        r = $urandom_range(3, 0);
        if (r == 1 && span < MAX_NODES)
            send(mk_item(KIND_LOAD, $urandom_range(MAX_NODES - 1, span),
                         $urandom_range(1023, 0), 1'b1, STEP_BITS'($urandom)));
        else if (r == 2)
            send(mk_item(KIND_QUERY, $urandom_range(1023, 0), $urandom_range(1023, 0),
                         1'($urandom_range(1, 0)), '0));
        else if (r == 3)
            send(mk_item(KIND_QUERY, $urandom_range(1023, 0), $urandom_range(1023, 0),
                         1'($urandom_range(1, 0)),
                         STEP_BITS'($urandom_range(65535, 1 << LOG_LEVELS))));
        else
            send(mk_item(KIND_NONE, $urandom_range(1023, 0), $urandom_range(1023, 0),
                         1'($urandom_range(1, 0)), STEP_BITS'($urandom)));
    endtask

    task automatic rand_query(int span);
        send(mk_item(KIND_QUERY, $urandom_range(span - 1, 0), $urandom_range(1023, 0),
                     1'($urandom_range(1, 0)), pick_steps()));
    endtask

    // Load or reload one node of the tree 0..span-1
    task automatic load_node(int v, int span, shape_t shp, int root_pct);
        bit root;
        root = (v == 0 && shp != SHAPE_LOOPY) || ($urandom_range(99, 0) < root_pct);
        send(mk_item(KIND_LOAD, v,
                     root ? $urandom_range(1023, 0) : pick_parent(v, span, shp),
                     root, STEP_BITS'($urandom)));
    endtask

    // One tree: load every node, full build, queries mixed with reloads,
    // rebuilds and noise items, then a build over a range no larger and a few more queries
    task automatic run_round(int span, shape_t shp);
        int order [MAX_NODES];
        int root_pct;
        int n_q;
        int r;
        int j;
        int tmp;
        root_pct = $urandom_range(8, 0);
        for (int i = 0; i < span; i++)
            order[i] = i;
        for (int i = span - 1; i > 0; i--)
        begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end

        for (int i = 0; i < span; i++)
        begin
            if ($urandom_range(99, 0) < 8)
                rand_noise(span);
            load_node(order[i], span, shp, root_pct);
        end

        write_span(span);
        send(mk_item(KIND_BUILD, $urandom_range(1023, 0), $urandom_range(1023, 0),
                     1'($urandom_range(1, 0)), STEP_BITS'($urandom)));

        n_q = $urandom_range(60, 20);
        for (int i = 0; i < n_q; i++)
        begin
            // Hold the input until every answer is back, at least once a round
            if (i == n_q / 2 || $urandom_range(99, 0) < 3)
                wait_results();
            r = $urandom_range(99, 0);
            if (r < 6)
                load_node($urandom_range(span - 1, 0), span, shp, root_pct);
            else if (r < 9)
                send(mk_item(KIND_BUILD, $urandom_range(1023, 0), $urandom_range(1023, 0),
                             1'($urandom_range(1, 0)), STEP_BITS'($urandom)));
            else if (r < 17)
                rand_noise(span);
            else
                rand_query(span);
        end

        // Build over part of the tree (none at zero); other entries keep
        // what the last full-range build left
        r = $urandom_range(2, 0);
        write_span((r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(span, 1));
        send(mk_item(KIND_BUILD, $urandom_range(1023, 0), $urandom_range(1023, 0),
                     1'($urandom_range(1, 0)), STEP_BITS'($urandom)));
        repeat ($urandom_range(15, 8))
            rand_query(span);
    endtask

    task automatic pick_round();
        int r;
        int span;
        r = $urandom_range(99, 0);
        if (r < 10)
            span = $urandom_range(2, 1);
        else if (r < 85)
            span = $urandom_range(64, 3);
        else
            span = $urandom_range(160, 65);
        run_round(span, shape_t'($urandom_range(3, 0)));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: four-node chain 3 -> 2 -> 1 -> 0, node 0 the root
        write_span(4);
        send(mk_item(KIND_LOAD, 0, 1023, 1'b1, 16'hFFFF));
        send(mk_item(KIND_LOAD, 1, 0, 1'b0, 16'h0000));
        send(mk_item(KIND_LOAD, 2, 1, 1'b0, 16'h0000));
        send(mk_item(KIND_LOAD, 3, 2, 1'b0, 16'h0000));
        send(mk_item(KIND_LOAD, 1023, 1023, 1'b1, 16'hFFFF));
        send(mk_item(KIND_NONE, 1023, 1023, 1'b1, 16'hFFFF));
        // zero steps and K beyond the table need no table read
        send(mk_item(KIND_QUERY, 1023, 0, 1'b0, 16'h0000));
        send(mk_item(KIND_QUERY, 0, 0, 1'b0, 16'hFFFF));
        send(mk_item(KIND_QUERY, 2, 0, 1'b0, 16'h0400));
        send(mk_item(KIND_BUILD, 0, 0, 1'b0, 16'h0000));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0001));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0003));
        // climb past the root
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0004));
        send(mk_item(KIND_QUERY, 0, 0, 1'b0, 16'h0001));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0200));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0000));
        // re-root node 2 without a rebuild: level 1 stays stale
        send(mk_item(KIND_LOAD, 2, 0, 1'b1, 16'h0000));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0002));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0001));
        // node count zero: the build changes nothing
        write_span(0);
        send(mk_item(KIND_BUILD, 0, 0, 1'b0, 16'h0000));
        send(mk_item(KIND_QUERY, 3, 0, 1'b0, 16'h0003));

        // Random trees until the item goal is reached
        while (items_sent < ITEM_GOAL)
            pick_round();

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
